// ----- rtl/csd_pkg.sv -----
// Shared constants and types for the closest segment distance block.
`default_nettype none
package csd_pkg;
   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_W = 32;
   localparam int DIST_W = 31;
   localparam int PARAM_BITS = 32;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [63:0] INIT_WIDE = 64'd10000 << COORD_FRAC_BITS;
   localparam logic [DIST_W-1:0] INIT_MIN_RESET =
      (INIT_WIDE > 64'(DIST_MAX)) ? DIST_MAX : INIT_WIDE[DIST_W-1:0];

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [DIST_W-1:0] dist_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type seg_start_x;
      coord_type seg_start_y;
      coord_type seg_end_x;
      coord_type seg_end_y;
      logic      last_segment;
   } req_type;
endpackage
`default_nettype wire

// ----- rtl/csd_if.sv -----
// Valid/ready channel interfaces for the closest segment distance block.
`default_nettype none
interface csd_req_if;
   logic             valid;
   logic             ready;
   csd_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface csd_rsp_if;
   logic              valid;
   logic              ready;
   csd_pkg::dist_type min_distance;
   modport source (output valid, output min_distance, input ready);
   modport sink (input valid, input min_distance, output ready);
endinterface

interface csd_csr_if;
   logic              valid;
   logic              ready;
   csd_pkg::dist_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/closest_segment_distance_xy.sv -----
// Top level: point to segment distance with a running minimum per query.
`default_nettype none
// Each transfer on req carries a point and a segment; the block computes the
// floored XY distance from the point to the segment and keeps a running
// minimum that starts at the csr value (reset 10000.0). On a transfer marked
// last_segment the minimum goes out on rsp and the start value is reloaded.
// Each item keeps req low until it is folded in, so a new transfer is taken
// only after the last one is done. An interior projection takes four
// products, a 32-step restoring divide for the projection parameter, two
// offset products, two squares, a 32-step square root, then saturate and fold.
// A projection clamped to an endpoint skips the divide and the offsets; a
// saturating residual skips the squares and the root.
// The divide and the root share one subtract/compare unit; products use one
// 34x34 signed multiplier, one product per cycle. A result waiting on rsp
// keeps req low until its transfer.
module closest_segment_distance_xy (
   input wire logic clock,
   input wire logic reset,
   csd_req_if.sink  req,
   csd_rsp_if.source rsp,
   csd_csr_if.sink  csr
);
   localparam logic [3:0] ST_IDLE = 4'd0, ST_MUL = 4'd1, ST_CHK = 4'd2,
      ST_DIV = 4'd3, ST_OFF = 4'd4, ST_RES = 4'd5, ST_SQ = 4'd6,
      ST_SQRT = 4'd7, ST_FOLD = 4'd8, ST_OUT = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   csd_pkg::req_type item_ff, item_in;
   logic signed [32:0] dx_ff, dy_ff, wx_ff, wy_ff, dx_in, dy_in, wx_in, wy_in;
   logic signed [67:0] dot_ff, dot_in;
   logic [66:0] len2_ff, len2_in;
   logic [67:0] rem_ff, rem_in;
   logic [31:0] t_ff, t_in;
   logic signed [33:0] rx_ff, ry_ff, rx_in, ry_in;
   logic [63:0] sq_ff, sq_in;
   logic [31:0] root_ff, root_in;
   logic [65:0] sqr_ff, sqr_in;
   csd_pkg::dist_type init_ff, init_in, run_ff, run_in, dist_ff, dist_in;
   csd_pkg::dist_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;

   // shared multiplier
   logic signed [33:0] ma, mb;
   logic signed [67:0] mp;
   assign mp = ma * mb;

   // shared subtract/compare unit
   logic [67:0] sub_a, sub_b, sub_d;
   assign sub_d = sub_a - sub_b;

   assign req.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.min_distance = out_ff;
   assign csr.ready = 1'b1;

   logic [67:0] rem_sh;
   logic [67:0] len2_x;
   logic [33:0] ax, ay;
   logic [63:0] offm;
   logic signed [33:0] offs;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; item_in = item_ff;
      dx_in = dx_ff; dy_in = dy_ff; wx_in = wx_ff; wy_in = wy_ff;
      dot_in = dot_ff; len2_in = len2_ff; rem_in = rem_ff; t_in = t_ff;
      rx_in = rx_ff; ry_in = ry_ff; sq_in = sq_ff; root_in = root_ff;
      sqr_in = sqr_ff; init_in = init_ff; run_in = run_ff; dist_in = dist_ff;
      out_in = out_ff; out_valid_in = out_valid_ff;
      ma = '0; mb = '0;
      sub_a = '0; sub_b = '0;
      rem_sh = {rem_ff[66:0], 1'b0};
      len2_x = {1'b0, len2_ff};
      offm = '0; offs = '0;
      ax = rx_ff[33] ? 34'(-rx_ff) : 34'(rx_ff);
      ay = ry_ff[33] ? 34'(-ry_ff) : 34'(ry_ff);
      if (csr.valid) init_in = csr.data;
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.data;
               dx_in = 33'(req.data.seg_end_x) - 33'(req.data.seg_start_x);
               dy_in = 33'(req.data.seg_end_y) - 33'(req.data.seg_start_y);
               wx_in = 33'(req.data.point_x) - 33'(req.data.seg_start_x);
               wy_in = 33'(req.data.point_y) - 33'(req.data.seg_start_y);
               cnt_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // four products: wx*dx, wy*dy, dx*dx, dy*dy
            unique case (cnt_ff[1:0])
               2'd0: begin ma = 34'(wx_ff); mb = 34'(dx_ff); end
               2'd1: begin ma = 34'(wy_ff); mb = 34'(dy_ff); end
               2'd2: begin ma = 34'(dx_ff); mb = 34'(dx_ff); end
               default: begin ma = 34'(dy_ff); mb = 34'(dy_ff); end
            endcase
            unique case (cnt_ff[1:0])
               2'd0: dot_in = mp;
               2'd1: dot_in = dot_ff + mp;
               2'd2: len2_in = 67'(mp);
               default: len2_in = len2_ff + 67'(mp);
            endcase
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) state_in = ST_CHK;
         end
         ST_CHK: begin
            cnt_in = '0; t_in = '0; rem_in = 68'(dot_ff);
            if (len2_ff == '0 || dot_ff <= 0) begin
               rx_in = 34'(wx_ff); ry_in = 34'(wy_ff); state_in = ST_SQ;
            end else if (68'(dot_ff) >= len2_x) begin
               rx_in = 34'(item_ff.point_x) - 34'(item_ff.seg_end_x);
               ry_in = 34'(item_ff.point_y) - 34'(item_ff.seg_end_y);
               state_in = ST_SQ;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // both operands stay below 2^67, so the top bit is the borrow
            sub_a = rem_sh; sub_b = len2_x;
            if (!sub_d[67]) begin
               rem_in = sub_d; t_in = {t_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh; t_in = {t_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(csd_pkg::PARAM_BITS - 1)) begin
               cnt_in = '0; state_in = ST_OFF;
            end
         end
         ST_OFF: begin
            ma = {2'b0, t_ff};
            if (cnt_ff[0]) mb = dy_ff[32] ? 34'(-dy_ff) : 34'(dy_ff);
            else mb = dx_ff[32] ? 34'(-dx_ff) : 34'(dx_ff);
            offm = 64'(mp);
            offs = {2'b0, offm[63:32]};
            if (!cnt_ff[0]) begin
               rx_in = 34'(wx_ff) - (dx_ff[32] ? -offs : offs);
               cnt_in = 6'd1;
            end else begin
               ry_in = 34'(wy_ff) - (dy_ff[32] ? -offs : offs);
               cnt_in = '0; state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (ax >= 34'h80000000 || ay >= 34'h80000000) begin
               dist_in = csd_pkg::DIST_MAX; state_in = ST_FOLD;
            end else begin
               ma = 34'(ax); mb = 34'(ax);
               if (!cnt_ff[0]) begin
                  sq_in = 64'(mp); cnt_in = 6'd1;
               end else begin
                  ma = 34'(ay); mb = 34'(ay);
                  sq_in = sq_ff + 64'(mp);
                  cnt_in = '0; root_in = '0; sqr_in = '0; state_in = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            // one result bit per step
            sub_a = {2'b0, sqr_ff[63:0], sq_ff[63:62]};
            sub_b = {34'b0, root_ff, 2'b01};
            sqr_in = {sqr_ff[63:0], sq_ff[63:62]};
            sq_in = {sq_ff[61:0], 2'b0};
            if (!sub_d[67]) begin
               sqr_in = sub_d[65:0]; root_in = {root_ff[30:0], 1'b1};
            end else begin
               root_in = {root_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) state_in = ST_RES;
         end
         ST_RES: begin
            dist_in = root_ff[31] ? csd_pkg::DIST_MAX : root_ff[30:0];
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            run_in = (dist_ff < run_ff) ? dist_ff : run_ff;
            if (item_ff.last_segment) begin
               out_in = run_in; out_valid_in = 1'b1; run_in = init_ff;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         init_ff <= csd_pkg::INIT_MIN_RESET;
         run_ff <= csd_pkg::INIT_MIN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         init_ff <= init_in;
         run_ff <= run_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff <= item_in; dx_ff <= dx_in; dy_ff <= dy_in;
      wx_ff <= wx_in; wy_ff <= wy_in; dot_ff <= dot_in; len2_ff <= len2_in;
      rem_ff <= rem_in; t_ff <= t_in; rx_ff <= rx_in; ry_ff <= ry_in;
      sq_ff <= sq_in; root_ff <= root_in; sqr_ff <= sqr_in;
      dist_ff <= dist_in; out_ff <= out_in;
   end
endmodule
`default_nettype wire

// ----- dv/closest_segment_distance_xy_tb.sv -----
// Testbench for closest_segment_distance_xy: random and directed segments against a predictor.
`timescale 1ns / 1ps

class seg_min_scoreboard;
   csd_pkg::dist_type  start_min;
   csd_pkg::dist_type  running_min;
   csd_pkg::dist_type  expected_min_q[$];
   int                 fails;

   function new();
      start_min   = csd_pkg::INIT_MIN_RESET;
      running_min = csd_pkg::INIT_MIN_RESET;
      fails       = 0;
   endfunction

   // A new start value only shows after the next reload.
   function void write_start_min(csd_pkg::dist_type value);
      start_min = value;
   endfunction

   function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function csd_pkg::dist_type segment_distance(csd_pkg::req_type it);
      longint px, py, sx, sy, ex, ey, dx, dy, qx, qy, rx, ry;
      logic signed [127:0] wx_w, wy_w, dx_w, dy_w, dot, len2, frac, off;
      longint unsigned ax, ay, root;
      px = it.point_x;      py = it.point_y;
      sx = it.seg_start_x;  sy = it.seg_start_y;
      ex = it.seg_end_x;    ey = it.seg_end_y;
      dx = ex - sx;
      dy = ey - sy;
      wx_w = px - sx;
      wy_w = py - sy;
      dx_w = dx;
      dy_w = dy;
      dot  = wx_w * dx_w + wy_w * dy_w;
      len2 = dx_w * dx_w + dy_w * dy_w;
      if (len2 == 0 || dot <= 0) begin
         qx = sx; qy = sy;
      end else if (dot >= len2) begin
         qx = ex; qy = ey;
      end else begin
         frac = (dot <<< 32) / len2;
         off  = (frac * (dx_w < 0 ? -dx_w : dx_w)) >>> 32;
         qx   = sx + (dx < 0 ? -longint'(off[63:0]) : longint'(off[63:0]));
         off  = (frac * (dy_w < 0 ? -dy_w : dy_w)) >>> 32;
         qy   = sy + (dy < 0 ? -longint'(off[63:0]) : longint'(off[63:0]));
      end
      rx = px - qx;
      ry = py - qy;
      ax = rx < 0 ? -rx : rx;
      ay = ry < 0 ? -ry : ry;
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) return csd_pkg::DIST_MAX;
      root = int_sqrt(ax * ax + ay * ay);
      if (root > 64'(csd_pkg::DIST_MAX)) return csd_pkg::DIST_MAX;
      return root[csd_pkg::DIST_W-1:0];
   endfunction

   function void note_item(csd_pkg::req_type it);
      csd_pkg::dist_type d;
      d = segment_distance(it);
      if (d < running_min) running_min = d;
      if (it.last_segment) begin
         expected_min_q = {expected_min_q, running_min};
         running_min = start_min;
      end
   endfunction

   function void check_result(csd_pkg::dist_type actual);
      csd_pkg::dist_type want;
      if (expected_min_q.size() == 0) begin
         $error("min_distance: unexpected transfer, actual %0h", actual);
         fails++;
         return;
      end
      want = expected_min_q.pop_front();
      if (actual !== want) begin
         $error("min_distance: expected %0h actual %0h", want, actual);
         fails++;
      end
   endfunction
endclass

module closest_segment_distance_xy_tb;
   localparam int ITEMS_PER_PHASE = 290;

   logic clock;
   logic reset;

   csd_req_if req_ch();
   csd_rsp_if rsp_ch();
   csd_csr_if csr_ch();

   closest_segment_distance_xy u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   seg_min_scoreboard sb = new();
   int  max_gap;
   int  max_stall;
   int  results_seen;
   int  stall_left;
   bit  long_hold_done;
   int  items_sent;

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: check each transfer, then draw the stall before the next one.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result(rsp_ch.min_distance);
         results_seen++;
         stall_left = max_stall == 0 ? 0 : $urandom_range(0, max_stall);
         if (results_seen == 30 && !long_hold_done) begin
            stall_left     = 600;
            long_hold_done = 1'b1;
         end
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic csd_pkg::req_type make_item(int px, int py, int sx, int sy, int ex,
                                                  int ey, bit last);
      csd_pkg::req_type it;
      it.point_x = px;      it.point_y = py;
      it.seg_start_x = sx;  it.seg_start_y = sy;
      it.seg_end_x = ex;    it.seg_end_y = ey;
      it.last_segment = last;
      return it;
   endfunction

   task automatic send_item(csd_pkg::req_type it);
      int gap;
      gap = max_gap == 0 ? 0 : $urandom_range(0, max_gap);
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(it);
      items_sent++;
   endtask

   task automatic release_req();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.expected_min_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_start_min(csd_pkg::dist_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_start_min(value);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_coord(int span_mode);
      case (span_mode)
         0: return $urandom;
         1: return int'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
         default: return int'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
      endcase
   endfunction

   task automatic random_queries(int count);
      int len, k, mode, sx, sy, ex, ey;
      while (count > 0) begin
         len  = $urandom_range(1, 6);
         mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
         for (k = 0; k < len; k++) begin
            sx = rand_coord(mode);
            sy = rand_coord(mode);
            ex = rand_coord(mode);
            ey = rand_coord(mode);
            // degenerate or axis-aligned segments now and then
            case ($urandom_range(0, 9))
               0: begin ex = sx; ey = sy; end
               1: ey = sy;
               2: ex = sx;
               default: ;
            endcase
            send_item(make_item(rand_coord(mode), rand_coord(mode), sx, sy, ex, ey,
                                k == len - 1));
            count--;
         end
      end
      release_req();
   endtask

   localparam int ONE = 32'h0001_0000;
   localparam int CMAX = 32'h7FFF_FFFF;
   localparam int CMIN = 32'h8000_0000;

   task automatic directed_items();
      // start, end and interior projections
      send_item(make_item(3*ONE, 4*ONE, 0, 0, 0, 0, 1));
      send_item(make_item(-5*ONE, 0, 0, 0, 10*ONE, 0, 1));
      send_item(make_item(20*ONE, ONE, 0, 0, 10*ONE, 0, 1));
      send_item(make_item(5*ONE, 7*ONE, 0, 0, 10*ONE, 0, 0));
      send_item(make_item(3*ONE, -2*ONE, 0, 0, 10*ONE, 0, 1));
      send_item(make_item(0, 5*ONE, 0, 0, 10*ONE, 0, 1));
      send_item(make_item(7*ONE, 3*ONE, 10*ONE, 0, 0, 0, 1));
      send_item(make_item(ONE + 7, 3*ONE - 1, -3*ONE, ONE, 9*ONE + 5, -7*ONE, 1));
      // coordinate extremes and saturating residuals
      send_item(make_item(CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, 1));
      send_item(make_item(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, 1));
      send_item(make_item(0, 0, CMIN, CMAX, CMAX, CMIN, 1));
      send_item(make_item(CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, 1));
      send_item(make_item(32'h4000_0000, 0, CMIN, 0, CMIN, 0, 1));
      send_item(make_item(0, 0, 0, 0, 0, 0, 1));
      // distance above the start value clips to it
      send_item(make_item(30000*ONE, 0, 0, 0, 0, 0, 1));
      send_item(make_item(-1, -1, CMIN, -1, CMAX, -1, 0));
      send_item(make_item(CMAX, CMAX, 0, 0, CMAX, CMAX, 0));
      send_item(make_item(100*ONE, 0, 0, 0, 0, 0, 1));
      release_req();
   endtask

   initial begin
      csd_pkg::dist_type start_values[5];
      int ph;
      start_values[0] = 31'd0;
      start_values[1] = csd_pkg::DIST_MAX;
      start_values[2] = csd_pkg::dist_type'($urandom);
      start_values[3] = 31'd1;
      start_values[4] = csd_pkg::INIT_MIN_RESET;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.data    <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.data    <= '0;
      stall_left     = 0;
      results_seen   = 0;
      long_hold_done = 1'b0;
      items_sent     = 0;
      max_gap        = 12;
      max_stall      = 12;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_items();
      random_queries(ITEMS_PER_PHASE - 20);
      for (ph = 0; ph < 5; ph++) begin
         drain();
         write_start_min(start_values[ph]);
         // alternate gap-free phases with ones that have idle gaps
         max_gap   = (ph % 2 == 0) ? 0 : 12;
         max_stall = (ph == 2) ? 0 : 12;
         random_queries(ph == 4 ? 60 : ITEMS_PER_PHASE - 30);
      end

      drain();
      if (sb.fails == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
